// ===== hdl/rbhc_pkg.sv =====
package rbhc_pkg;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PWM_TOP      = 3'd0,
    CFG_HUE_STEP     = 3'd1,
    CFG_PHASE_STEP   = 3'd2,
    CFG_BRIGHT_FLOOR = 3'd3,
    CFG_BRIGHT_SPAN  = 3'd4
  } rbhc_cfg_e;

  // Field and register widths.
  localparam int CmpW       = 16;
  localparam int HueW       = 10;
  localparam int HueStepW   = 10;
  localparam int PhaseStepW = 9;
  localparam int DegW       = 9;

  localparam logic [CmpW-1:0]       PWM_TOP_RST    = 16'd999;
  localparam logic [HueStepW-1:0]   HUE_STEP_RST   = 10'd1;
  localparam logic [PhaseStepW-1:0] PHASE_STEP_RST = 9'd1;
  localparam logic [CmpW-1:0]       FLOOR_RST      = 16'd6554;
  localparam logic [CmpW-1:0]       SPAN_RST       = 16'd52429;

  // Angles: degrees for the breathing phase, half-degrees for the hue.
  localparam int DEG_FULL    = 360;
  localparam int QUARTER     = 90;
  localparam int HUE_WRAP    = 720;
  localparam int SECTOR_SPAN = 120;
  localparam int GW          = 7;

  // Quarter-wave sine, round(sin(d) * 65536) for d = 0..90 degrees.
  localparam int SineW    = 17;
  localparam int SineIdxW = 7;
  localparam logic [SineW-1:0] SINE_ROM [0:90] = '{
    17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
    17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
    17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
    17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
    17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
    17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
    17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
    17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
    17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
    17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
    17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
    17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
    17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  // Command to the shared serial arithmetic unit.
  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } rbhc_op_e;

  typedef struct packed {
    logic     start;
    rbhc_op_e op;
  } rbhc_cmd_t;

endpackage

// ===== hdl/rbhc_tick_if.sv =====
interface rbhc_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

// ===== hdl/rbhc_cmp_if.sv =====
interface rbhc_cmp_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_compare;
  logic [15:0] green_compare;
  logic [15:0] blue_compare;

  modport source (output valid, output red_compare, output green_compare,
                  output blue_compare, input ready);
  modport sink (input valid, input red_compare, input green_compare,
                input blue_compare, output ready);
endinterface

// ===== hdl/rgb_breathing_hue_cycler.sv =====
// Channel   Dir  Handshake          Word
// tick_i    in   valid/ready        tick (1 bit)
// cmp_o     out  valid/ready        red_compare, green_compare, blue_compare (16 bits each)
// cfg       in   cfg_we_i, no wait  cfg_idx_i selects the register, cfg_wdata_i holds the value
//
// A word with tick set yields one output word, computed step by step on the single
// bit-serial multiply/divide unit.
// A word with tick clear is taken and yields nothing.
// Reset puts the position registers at zero and loads the documented register defaults.
// A new tick word is taken whenever the sequencer is idle, even while the previous result
// waits in the output register; a stalled output only holds the sequencer at its last step.
module rgb_breathing_hue_cycler #(
  parameter int PHASE_STEPS   = 360,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rbhc_tick_if.sink                     tick_i,
  rbhc_cmp_if.source                    cmp_o,
  input  logic                          cfg_we_i,
  input  logic [rbhc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rbhc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import rbhc_pkg::*;

  // Fraction width and the widths of the serial unit's operands.
  localparam int FB     = FRACTION_BITS;
  localparam int PS     = PHASE_STEPS;
  localparam int WW     = (2*FB+1 > FB+17) ? 2*FB+1 : FB+17;
  localparam int MBW    = (FB+1 > CmpW) ? FB+1 : CmpW;
  localparam int DIVMAX = (PS > SECTOR_SPAN) ? PS : SECTOR_SPAN;
  localparam int DW     = $clog2(DIVMAX) + 1;
  localparam int CW     = $clog2(WW+1);
  localparam int PHW    = $clog2(PS);
  localparam int PDW    = PHW + DegW;
  localparam int PUW    = $clog2(PS + (1 << PhaseStepW) - 1);
  localparam int MIXW   = FB + 1 + GW;
  // Moving a Q16 value to the internal fraction is a left or a right shift.
  localparam int UP     = (FB > 16) ? FB - 16 : 0;
  localparam int DN     = (FB < 16) ? 16 - FB : 0;

  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEG,
    S_BRIGHT,
    S_MIXMUL,
    S_MIXDIV,
    S_SCALEV,
    S_SCALEX,
    S_PHASE,
    S_EMIT
  } state_e;

  // The six 60-degree hue sectors, named by the color pair they blend.
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  // Configuration registers.
  logic [CmpW-1:0]       pwm_top_q;
  logic [HueStepW-1:0]   hue_step_q;
  logic [PhaseStepW-1:0] phase_step_q;
  logic [CmpW-1:0]       floor_q;
  logic [CmpW-1:0]       span_q;

  // Sequencer and position state.
  state_e           state_q;
  rbhc_cmd_t        cmd_q;
  logic             out_valid_q;
  logic [HueW-1:0]  hue_q;
  logic [PHW-1:0]   phase_q;

  // Intermediate results.
  logic [FB:0]      raised_q;
  logic [FB:0]      v_q;
  logic [FB:0]      x_q;
  logic [CmpW-1:0]  cmpv_q;
  logic [CmpW-1:0]  cmpx_q;
  logic [CmpW-1:0]  red_q;
  logic [CmpW-1:0]  green_q;
  logic [CmpW-1:0]  blue_q;

  // Serial unit interface.
  logic [WW-1:0]    unit_a;
  logic [MBW-1:0]   unit_b;
  logic [DW-1:0]    unit_d;
  logic [CW-1:0]    unit_count;
  logic             unit_done;
  logic [WW-1:0]    unit_res;
  logic [DW-1:0]    unit_rem;

  logic             in_acc;
  logic             emit_load;

  logic [10:0]          hsum;
  logic [HueW-1:0]      hue_d;
  logic [PDW-1:0]       deg_prod;
  logic [PUW-1:0]       psum;
  logic [FB-1:0]        floor_f;
  logic [FB-1:0]        span_f;
  logic [16+UP-1:0]     floor_w;
  logic [16+UP-1:0]     span_w;

  logic [DegW-1:0]      deg;
  logic [DegW-1:0]      deg_base;
  logic                 quad_odd;
  logic                 quad_neg;
  logic [SineIdxW-1:0]  k;
  logic [SineIdxW-1:0]  sidx;
  logic [SineW-1:0]     mag17;
  logic [SineW+UP-1:0]  mag_w;
  logic [FB:0]          mag_f;
  logic [FB+1:0]        rsum;
  logic [FB:0]          raised_d;
  logic [FB:0]          bsum;
  logic [FB:0]          v_d;
  logic [CmpW-1:0]      cmp_d;

  sector_e              sector;
  logic [HueW-1:0]      sec_base;
  logic                 sec_odd;
  logic [GW-1:0]        f;
  logic [GW-1:0]        g;
  logic [CmpW-1:0]      red_d;
  logic [CmpW-1:0]      green_d;
  logic [CmpW-1:0]      blue_d;

  assign in_acc    = tick_i.valid && tick_i.ready;
  assign emit_load = (state_q == S_EMIT) && (!out_valid_q || cmp_o.ready);

  assign tick_i.ready        = (state_q == S_IDLE);
  assign cmp_o.valid         = out_valid_q;
  assign cmp_o.red_compare   = red_q;
  assign cmp_o.green_compare = green_q;
  assign cmp_o.blue_compare  = blue_q;

  // Hue advance: the sum stays below three turns, so two conditional subtracts suffice.
  assign hsum = 11'(hue_q) + 11'(hue_step_q);
  always_comb begin
    if (hsum >= 11'(2*HUE_WRAP)) begin
      hue_d = HueW'(hsum - 11'(2*HUE_WRAP));
    end else if (hsum >= 11'(HUE_WRAP)) begin
      hue_d = HueW'(hsum - 11'(HUE_WRAP));
    end else begin
      hue_d = HueW'(hsum);
    end
  end

  // The phase is scaled to degrees by the divider; the times-360 is a constant multiply.
  assign deg_prod = PDW'(phase_q) * PDW'(DEG_FULL);
  // The phase wraps through the divider's remainder, since the step may exceed a turn.
  assign psum     = PUW'(phase_q) + PUW'(phase_step_q);

  assign floor_w = (16+UP)'(floor_q) << UP;
  assign span_w  = (16+UP)'(span_q) << UP;
  assign floor_f = FB'(floor_w >> DN);
  assign span_f  = FB'(span_w >> DN);

  // Raised sine from the degree quotient: fold into the first quadrant, look up, and
  // add or subtract the magnitude from one depending on the half-wave.
  assign deg = DegW'(unit_res);
  always_comb begin
    if (deg >= DegW'(3*QUARTER)) begin
      deg_base = DegW'(3*QUARTER);
      quad_odd = 1'b1;
      quad_neg = 1'b1;
    end else if (deg >= DegW'(2*QUARTER)) begin
      deg_base = DegW'(2*QUARTER);
      quad_odd = 1'b0;
      quad_neg = 1'b1;
    end else if (deg >= DegW'(QUARTER)) begin
      deg_base = DegW'(QUARTER);
      quad_odd = 1'b1;
      quad_neg = 1'b0;
    end else begin
      deg_base = '0;
      quad_odd = 1'b0;
      quad_neg = 1'b0;
    end
  end
  assign k        = SineIdxW'(deg - deg_base);
  assign sidx     = quad_odd ? (SineIdxW'(QUARTER) - k) : k;
  assign mag17    = SINE_ROM[sidx];
  assign mag_w    = (SineW+UP)'(mag17) << UP;
  assign mag_f    = (FB+1)'(mag_w >> DN);
  assign rsum     = quad_neg ? ((FB+2)'(ONE) - (FB+2)'(mag_f))
                             : ((FB+2)'(ONE) + (FB+2)'(mag_f));
  assign raised_d = rsum[FB+1:1];

  // Brightness: floor plus the truncated product, clamped at full scale.
  assign bsum = (FB+1)'(floor_f) + (FB+1)'(unit_res >> FB);
  assign v_d  = (bsum > ONE) ? ONE : bsum;

  // Channel scaling: the product of a value at most one and the top never exceeds the top.
  assign cmp_d = pwm_top_q - CmpW'(unit_res >> FB);

  // Hue sector and position within it, in half-degrees.
  always_comb begin
    if (hue_q >= HueW'(5*SECTOR_SPAN)) begin
      sector   = SEC_MR;
      sec_base = HueW'(5*SECTOR_SPAN);
    end else if (hue_q >= HueW'(4*SECTOR_SPAN)) begin
      sector   = SEC_BM;
      sec_base = HueW'(4*SECTOR_SPAN);
    end else if (hue_q >= HueW'(3*SECTOR_SPAN)) begin
      sector   = SEC_CB;
      sec_base = HueW'(3*SECTOR_SPAN);
    end else if (hue_q >= HueW'(2*SECTOR_SPAN)) begin
      sector   = SEC_GC;
      sec_base = HueW'(2*SECTOR_SPAN);
    end else if (hue_q >= HueW'(SECTOR_SPAN)) begin
      sector   = SEC_YG;
      sec_base = HueW'(SECTOR_SPAN);
    end else begin
      sector   = SEC_RY;
      sec_base = '0;
    end
  end
  assign sec_odd = (sector == SEC_YG) || (sector == SEC_CB) || (sector == SEC_MR);
  assign f       = GW'(hue_q - sec_base);
  // Rising edge of a sector uses f, falling edge uses its complement.
  assign g       = sec_odd ? (GW'(SECTOR_SPAN) - f) : f;

  // A dark channel compares at the full top.
  always_comb begin
    red_d   = pwm_top_q;
    green_d = pwm_top_q;
    blue_d  = pwm_top_q;
    unique case (sector)
      SEC_RY: begin
        red_d   = cmpv_q;
        green_d = cmpx_q;
      end
      SEC_YG: begin
        red_d   = cmpx_q;
        green_d = cmpv_q;
      end
      SEC_GC: begin
        green_d = cmpv_q;
        blue_d  = cmpx_q;
      end
      SEC_CB: begin
        green_d = cmpx_q;
        blue_d  = cmpv_q;
      end
      SEC_BM: begin
        red_d  = cmpx_q;
        blue_d = cmpv_q;
      end
      default: begin
        red_d  = cmpv_q;
        blue_d = cmpx_q;
      end
    endcase
  end

  // Operands for the serial unit, selected by the step that is about to start.
  // Dividends are left-aligned so that the divider runs only over their real width.
  always_comb begin
    unit_a     = '0;
    unit_b     = '0;
    unit_d     = '0;
    unit_count = '0;
    unique case (state_q)
      S_DEG: begin
        unit_a     = WW'(deg_prod) << (WW - PDW);
        unit_d     = DW'(PS);
        unit_count = CW'(PDW);
      end
      S_BRIGHT: begin
        unit_a     = WW'(span_f);
        unit_b     = MBW'(raised_q);
        unit_count = CW'(FB + 1);
      end
      S_MIXMUL: begin
        unit_a     = WW'(v_q);
        unit_b     = MBW'(g);
        unit_count = CW'(GW);
      end
      S_MIXDIV: begin
        unit_a     = unit_res << (WW - MIXW);
        unit_d     = DW'(SECTOR_SPAN);
        unit_count = CW'(MIXW);
      end
      S_SCALEV: begin
        unit_a     = WW'(v_q);
        unit_b     = MBW'(pwm_top_q);
        unit_count = CW'(CmpW);
      end
      S_SCALEX: begin
        unit_a     = WW'(x_q);
        unit_b     = MBW'(pwm_top_q);
        unit_count = CW'(CmpW);
      end
      S_PHASE: begin
        unit_a     = WW'(psum) << (WW - PUW);
        unit_d     = DW'(PS);
        unit_count = CW'(PUW);
      end
      default: begin
      end
    endcase
  end

  rbhc_serial_unit #(
    .WW  (WW),
    .MBW (MBW),
    .DW  (DW)
  ) u_serial (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_q),
    .count_i  (unit_count),
    .a_i      (unit_a),
    .b_i      (unit_b),
    .d_i      (unit_d),
    .done_o   (unit_done),
    .result_o (unit_res),
    .rem_o    (unit_rem)
  );

  // Configuration writes; an index beyond the register list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_top_q    <= PWM_TOP_RST;
      hue_step_q   <= HUE_STEP_RST;
      phase_step_q <= PHASE_STEP_RST;
      floor_q      <= FLOOR_RST;
      span_q       <= SPAN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PWM_TOP:      pwm_top_q    <= cfg_wdata_i;
        CFG_HUE_STEP:     hue_step_q   <= cfg_wdata_i[HueStepW-1:0];
        CFG_PHASE_STEP:   phase_step_q <= cfg_wdata_i[PhaseStepW-1:0];
        CFG_BRIGHT_FLOOR: floor_q      <= cfg_wdata_i;
        CFG_BRIGHT_SPAN:  span_q       <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Sequencer. Each step launches the serial unit and waits for its done pulse.
  // The hue moves on acceptance; the phase moves only after the brightness used the old one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '{start: 1'b0, op: OP_MUL};
      out_valid_q <= 1'b0;
      hue_q       <= '0;
      phase_q     <= '0;
    end else begin
      cmd_q <= '{start: 1'b0, op: OP_MUL};
      if (cmp_o.valid && cmp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && tick_i.tick) begin
            hue_q   <= hue_d;
            state_q <= S_DEG;
            cmd_q   <= '{start: 1'b1, op: OP_DIV};
          end
        end
        S_DEG: begin
          if (unit_done) begin
            state_q <= S_BRIGHT;
            cmd_q   <= '{start: 1'b1, op: OP_MUL};
          end
        end
        S_BRIGHT: begin
          if (unit_done) begin
            state_q <= S_MIXMUL;
            cmd_q   <= '{start: 1'b1, op: OP_MUL};
          end
        end
        S_MIXMUL: begin
          if (unit_done) begin
            state_q <= S_MIXDIV;
            cmd_q   <= '{start: 1'b1, op: OP_DIV};
          end
        end
        S_MIXDIV: begin
          if (unit_done) begin
            state_q <= S_SCALEV;
            cmd_q   <= '{start: 1'b1, op: OP_MUL};
          end
        end
        S_SCALEV: begin
          if (unit_done) begin
            state_q <= S_SCALEX;
            cmd_q   <= '{start: 1'b1, op: OP_MUL};
          end
        end
        S_SCALEX: begin
          if (unit_done) begin
            state_q <= S_PHASE;
            cmd_q   <= '{start: 1'b1, op: OP_DIV};
          end
        end
        S_PHASE: begin
          if (unit_done) begin
            phase_q <= PHW'(unit_rem);
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers capture each step's result as the unit reports done.
  always_ff @(posedge clk_i) begin
    if (unit_done) begin
      case (state_q)
        S_DEG:    raised_q <= raised_d;
        S_BRIGHT: v_q      <= v_d;
        S_MIXDIV: x_q      <= (FB+1)'(unit_res);
        S_SCALEV: cmpv_q   <= cmp_d;
        S_SCALEX: cmpx_q   <= cmp_d;
        default: begin
        end
      endcase
    end
    if (emit_load) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

`ifndef SYNTHESIS
  // A tick word starts the degree division in the very next cycle.
  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && tick_i.tick) |=> (cmd_q.start && (cmd_q.op == OP_DIV)))
    else $error("tick accepted without launching the degree division");

  // The positions never leave their range.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (11'(hue_q) < 11'(HUE_WRAP)) && (32'(phase_q) < 32'(PS)))
    else $error("hue or phase position out of range");

  // A result appears only after the last step of the sequence.
  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("output valid raised outside the emit step");

  // The unit reports done only while a step is waiting for it.
  a_done_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> ((state_q != S_IDLE) && (state_q != S_EMIT)))
    else $error("serial unit done with no step pending");
`endif

endmodule

// ===== hdl/rbhc_serial_unit.sv =====
// Shift-and-add multiplier and restoring divider, one bit per cycle.
module rbhc_serial_unit #(
  parameter int WW  = 33,
  parameter int MBW = 17,
  parameter int DW  = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rbhc_pkg::rbhc_cmd_t     cmd_i,
  input  logic [$clog2(WW+1)-1:0] count_i,
  input  logic [WW-1:0]           a_i,
  input  logic [MBW-1:0]          b_i,
  input  logic [DW-1:0]           d_i,
  output logic                    done_o,
  output logic [WW-1:0]           result_o,
  output logic [DW-1:0]           rem_o
);
  import rbhc_pkg::*;

  localparam int CW = $clog2(WW+1);

  logic           busy_q;
  logic           done_q;
  logic [CW-1:0]  cnt_q;
  rbhc_op_e       op_q;
  logic [WW-1:0]  acc_q;
  logic [WW-1:0]  opnd_q;
  logic [MBW-1:0] mplr_q;
  logic [DW-1:0]  rem_q;
  logic [DW-1:0]  div_q;

  logic [DW-1:0]  rem_sh;
  logic           rem_ge;

  // The divider pulls the dividend in from the top; quotient bits enter at the bottom.
  assign rem_sh = {rem_q[DW-2:0], acc_q[WW-1]};
  assign rem_ge = (rem_sh >= div_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= count_i;
        op_q   <= cmd_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q  <= (cmd_i.op == OP_DIV) ? a_i : '0;
      opnd_q <= a_i;
      mplr_q <= b_i;
      rem_q  <= '0;
      div_q  <= d_i;
    end else if (busy_q) begin
      if (op_q == OP_MUL) begin
        if (mplr_q[0]) begin
          acc_q <= acc_q + opnd_q;
        end
        opnd_q <= opnd_q << 1;
        mplr_q <= mplr_q >> 1;
      end else begin
        acc_q <= {acc_q[WW-2:0], rem_ge};
        rem_q <= rem_ge ? (rem_sh - div_q) : rem_sh;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;
  assign rem_o    = rem_q;

endmodule
